// ===== rtl/robi_pkg.sv =====
// shared types, widths and helpers for the ray versus oriented box pipeline
package robi_pkg;

  localparam int unsigned DEN_W = 52;
  localparam int unsigned T_W   = 31;
  localparam logic [T_W-1:0] T_MAX = '1;

  typedef enum logic [1:0] {
    KIND_NONE    = 2'd0,
    KIND_POINT   = 2'd1,
    KIND_SEGMENT = 2'd2
  } hit_kind_e;

  typedef struct packed {
    logic den_pos;
    logic den_neg;
    logic num_pos;
  } edge_t;

  function automatic int unsigned num_width(int unsigned frac_bits);
    int unsigned w;
    w = (frac_bits + 31 > 51) ? frac_bits + 31 : 51;
    return w + 2;
  endfunction

endpackage

// ===== rtl/robi_xform.sv =====
// box space transform: edge numerators and denominators with signs and magnitudes
module robi_xform #(
  parameter int unsigned FRAC_BITS = 16,
  localparam int unsigned NUM_W = robi_pkg::num_width(FRAC_BITS)
) (
  input  logic                                     clk_i,
  input  logic                                     rst_ni,
  input  logic                                     en_i,
  input  logic                                     valid_i,
  input  logic signed [31:0]                       ray_origin_x_i,
  input  logic signed [31:0]                       ray_origin_y_i,
  input  logic signed [31:0]                       ray_dir_x_i,
  input  logic signed [31:0]                       ray_dir_y_i,
  input  logic signed [31:0]                       box_center_x_i,
  input  logic signed [31:0]                       box_center_y_i,
  input  logic signed [17:0]                       axis_u_x_i,
  input  logic signed [17:0]                       axis_u_y_i,
  input  logic signed [17:0]                       axis_v_x_i,
  input  logic signed [17:0]                       axis_v_y_i,
  input  logic [30:0]                              half_extent_u_i,
  input  logic [30:0]                              half_extent_v_i,
  output logic                                     valid_o,
  output robi_pkg::edge_t [3:0]                    edge_o,
  output logic [3:0][NUM_W-1:0]                    num_mag_o,
  output logic [3:0][robi_pkg::DEN_W-1:0]          den_mag_o
);
  import robi_pkg::*;

  localparam int unsigned EXT_W = 31 + FRAC_BITS;

  logic [4:0] vld_q;

  // stage 1
  logic signed [32:0] rx_q, ry_q;
  logic signed [31:0] dx_q, dy_q;
  logic signed [17:0] ux_q, uy_q, vx_q, vy_q;
  logic [30:0]        hu_q, hv_q;
  // stage 2
  logic signed [50:0] mrx_u_q, mry_u_q, mrx_v_q, mry_v_q;
  logic signed [49:0] mdx_u_q, mdy_u_q, mdx_v_q, mdy_v_q;
  logic [30:0]        hu2_q, hv2_q;
  // stage 3
  logic signed [51:0] bo_u_q, bo_v_q;
  logic signed [50:0] bd_u_q, bd_v_q;
  logic [EXT_W-1:0]   eu_q, ev_q;
  // stage 4
  logic signed [NUM_W-1:0] num_d [4];
  logic signed [NUM_W-1:0] num_q [4];
  logic signed [DEN_W-1:0] den_d [4];
  logic signed [DEN_W-1:0] den_q [4];
  // stage 5
  edge_t [3:0]             edge_d, edge_q;
  logic [3:0][NUM_W-1:0]   num_mag_d, num_mag_q;
  logic [3:0][DEN_W-1:0]   den_mag_d, den_mag_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[3:0], valid_i};
    end
  end

  always_comb begin
    logic signed [NUM_W-1:0] bou, bov, eus, evs;
    bou = NUM_W'(bo_u_q);
    bov = NUM_W'(bo_v_q);
    eus = NUM_W'($signed({1'b0, eu_q}));
    evs = NUM_W'($signed({1'b0, ev_q}));
    num_d[0] = -bou - eus;
    num_d[1] = bou - eus;
    num_d[2] = -bov - evs;
    num_d[3] = bov - evs;
    den_d[0] = DEN_W'(bd_u_q);
    den_d[1] = -DEN_W'(bd_u_q);
    den_d[2] = DEN_W'(bd_v_q);
    den_d[3] = -DEN_W'(bd_v_q);
  end

  always_comb begin
    for (int e = 0; e < 4; e++) begin
      edge_d[e].num_pos = !num_q[e][NUM_W-1] && (num_q[e] != '0);
      edge_d[e].den_pos = !den_q[e][DEN_W-1] && (den_q[e] != '0);
      edge_d[e].den_neg = den_q[e][DEN_W-1];
      num_mag_d[e] = num_q[e][NUM_W-1] ? NUM_W'(-num_q[e]) : NUM_W'(num_q[e]);
      den_mag_d[e] = den_q[e][DEN_W-1] ? DEN_W'(-den_q[e]) : DEN_W'(den_q[e]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rx_q    <= 33'(ray_origin_x_i) - 33'(box_center_x_i);
      ry_q    <= 33'(ray_origin_y_i) - 33'(box_center_y_i);
      dx_q    <= ray_dir_x_i;
      dy_q    <= ray_dir_y_i;
      ux_q    <= axis_u_x_i;
      uy_q    <= axis_u_y_i;
      vx_q    <= axis_v_x_i;
      vy_q    <= axis_v_y_i;
      hu_q    <= half_extent_u_i;
      hv_q    <= half_extent_v_i;

      mrx_u_q <= 51'(rx_q) * 51'(ux_q);
      mry_u_q <= 51'(ry_q) * 51'(uy_q);
      mrx_v_q <= 51'(rx_q) * 51'(vx_q);
      mry_v_q <= 51'(ry_q) * 51'(vy_q);
      mdx_u_q <= 50'(dx_q) * 50'(ux_q);
      mdy_u_q <= 50'(dy_q) * 50'(uy_q);
      mdx_v_q <= 50'(dx_q) * 50'(vx_q);
      mdy_v_q <= 50'(dy_q) * 50'(vy_q);
      hu2_q   <= hu_q;
      hv2_q   <= hv_q;

      bo_u_q  <= 52'(mrx_u_q) + 52'(mry_u_q);
      bo_v_q  <= 52'(mrx_v_q) + 52'(mry_v_q);
      bd_u_q  <= 51'(mdx_u_q) + 51'(mdy_u_q);
      bd_v_q  <= 51'(mdx_v_q) + 51'(mdy_v_q);
      eu_q    <= EXT_W'(hu2_q) << FRAC_BITS;
      ev_q    <= EXT_W'(hv2_q) << FRAC_BITS;

      num_q   <= num_d;
      den_q   <= den_d;

      edge_q    <= edge_d;
      num_mag_q <= num_mag_d;
      den_mag_q <= den_mag_d;
    end
  end

  assign valid_o   = vld_q[4];
  assign edge_o    = edge_q;
  assign num_mag_o = num_mag_q;
  assign den_mag_o = den_mag_q;

endmodule

// ===== rtl/robi_div.sv =====
// pipelined restoring divider: a saturation check stage, then one quotient bit per stage, saturating
module robi_div #(
  parameter int unsigned FRAC_BITS = 16,
  localparam int unsigned NUM_W = robi_pkg::num_width(FRAC_BITS)
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          en_i,
  input  logic                          valid_i,
  input  robi_pkg::edge_t               edge_i,
  input  logic [NUM_W-1:0]              num_mag_i,
  input  logic [robi_pkg::DEN_W-1:0]    den_mag_i,
  output logic                          valid_o,
  output robi_pkg::edge_t               edge_o,
  output logic [robi_pkg::T_W-1:0]      quot_o,
  output logic                          inexact_o
);
  import robi_pkg::*;

  localparam int unsigned MW = NUM_W + FRAC_BITS;
  localparam int unsigned CW = (MW > DEN_W + T_W) ? MW : DEN_W + T_W;
  localparam int unsigned NS = T_W + 1;

  logic [NS-1:0]    vld_q;
  logic [CW-1:0]    rem_d [NS];
  logic [CW-1:0]    rem_q [NS];
  logic [T_W-1:0]   q_d   [NS];
  logic [T_W-1:0]   q_q   [NS];
  logic [DEN_W-1:0] b_q   [NS];
  logic [NS-1:0]    sat_d, sat_q;
  edge_t            edge_q [NS];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[NS-2:0], valid_i};
    end
  end

  always_comb begin
    logic [CW-1:0] shifted;
    logic          take;
    rem_d[0] = CW'({num_mag_i, FRAC_BITS'(0)});
    q_d[0]   = '0;
    sat_d[0] = rem_d[0] >= (CW'(den_mag_i) << T_W);
    for (int j = 1; j < NS; j++) begin
      shifted  = CW'(b_q[j-1]) << (T_W - j);
      take     = !sat_q[j-1] && (rem_q[j-1] >= shifted);
      rem_d[j] = take ? rem_q[j-1] - shifted : rem_q[j-1];
      q_d[j]   = q_q[j-1];
      q_d[j][T_W-j] = take;
      sat_d[j] = sat_q[j-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q     <= rem_d;
      q_q       <= q_d;
      sat_q     <= sat_d;
      b_q[0]    <= den_mag_i;
      edge_q[0] <= edge_i;
      for (int j = 1; j < NS; j++) begin
        b_q[j]    <= b_q[j-1];
        edge_q[j] <= edge_q[j-1];
      end
    end
  end

  assign valid_o   = vld_q[NS-1];
  assign edge_o    = edge_q[NS-1];
  assign quot_o    = sat_q[NS-1] ? T_MAX : q_q[NS-1];
  assign inexact_o = sat_q[NS-1] || (rem_q[NS-1] != '0);

endmodule

// ===== rtl/robi_clip.sv =====
// four clipping stages, one box edge per stage; the last stage register drives the result
module robi_clip (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             en_i,
  input  logic                             valid_i,
  input  robi_pkg::edge_t [3:0]            edge_i,
  input  logic [3:0][robi_pkg::T_W-1:0]    quot_i,
  input  logic [3:0]                       inexact_i,
  output logic                             valid_o,
  output logic                             hit_o,
  output robi_pkg::hit_kind_e              hit_kind_o,
  output logic [robi_pkg::T_W-1:0]         near_distance_o
);
  import robi_pkg::*;

  typedef struct packed {
    logic           keep;
    logic [T_W-1:0] t0;
    logic [T_W-1:0] t1;
  } clip_t;

  localparam clip_t CLIP_INIT = '{keep: 1'b1, t0: '0, t1: T_MAX};

  function automatic clip_t clip_step(clip_t c, edge_t e, logic [T_W-1:0] q, logic nx);
    clip_t r;
    logic  gt0;
    logic  gt1;
    r   = c;
    gt0 = 1'b0;
    gt1 = 1'b0;
    if (c.keep) begin
      if (e.den_pos) begin
        gt1 = e.num_pos && ((q > c.t1) || ((q == c.t1) && nx));
        gt0 = e.num_pos && ((q > c.t0) || ((q == c.t0) && nx));
        if (gt1) begin
          r.keep = 1'b0;
        end else if (gt0) begin
          r.t0 = q;
        end
      end else if (e.den_neg) begin
        gt0 = e.num_pos || (q < c.t0);
        gt1 = e.num_pos || (q < c.t1);
        if (gt0) begin
          r.keep = 1'b0;
        end else if (gt1) begin
          r.t1 = q;
        end
      end else begin
        r.keep = !e.num_pos;
      end
    end
    return r;
  endfunction

  logic [3:0]            vld_q;
  clip_t                 c_d [4];
  clip_t                 c_q [4];
  edge_t [3:0]           e_q [3];
  logic [3:0][T_W-1:0]   qt_q [3];
  logic [3:0]            nx_q [3];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[2:0], valid_i};
    end
  end

  always_comb begin
    c_d[0] = clip_step(CLIP_INIT, edge_i[0], quot_i[0], inexact_i[0]);
    for (int i = 1; i < 4; i++) begin
      c_d[i] = clip_step(c_q[i-1], e_q[i-1][i], qt_q[i-1][i], nx_q[i-1][i]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      c_q     <= c_d;
      e_q[0]  <= edge_i;
      qt_q[0] <= quot_i;
      nx_q[0] <= inexact_i;
      for (int i = 1; i < 3; i++) begin
        e_q[i]  <= e_q[i-1];
        qt_q[i] <= qt_q[i-1];
        nx_q[i] <= nx_q[i-1];
      end
    end
  end

  assign valid_o         = vld_q[3];
  assign hit_o           = c_q[3].keep;
  assign hit_kind_o      = !c_q[3].keep ? KIND_NONE :
                           (c_q[3].t1 > c_q[3].t0) ? KIND_SEGMENT : KIND_POINT;
  assign near_distance_o = c_q[3].keep ? c_q[3].t0 : '0;

endmodule

// ===== rtl/ray_oriented_box_intersect.sv =====
// top level: 2d ray against oriented box, liang-barsky clipping pipeline
// registered stages from request accept to result valid: 5 transform,
// 32 divider, 4 clipping stages
// throughput: one request per cycle; a stalled result freezes the whole pipeline
// reset clears the stage valid bits only
module ray_oriented_box_intersect #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic signed [31:0] ray_origin_x_i,
  input  logic signed [31:0] ray_origin_y_i,
  input  logic signed [31:0] ray_dir_x_i,
  input  logic signed [31:0] ray_dir_y_i,
  input  logic signed [31:0] box_center_x_i,
  input  logic signed [31:0] box_center_y_i,
  input  logic signed [17:0] axis_u_x_i,
  input  logic signed [17:0] axis_u_y_i,
  input  logic signed [17:0] axis_v_x_i,
  input  logic signed [17:0] axis_v_y_i,
  input  logic [30:0]        half_extent_u_i,
  input  logic [30:0]        half_extent_v_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic               hit_o,
  output logic [1:0]         hit_kind_o,
  output logic [30:0]        near_distance_o
);
  import robi_pkg::*;

  localparam int unsigned NUM_W = num_width(FRAC_BITS);

  logic                  en;
  logic                  xf_valid;
  edge_t [3:0]           xf_edge;
  logic [3:0][NUM_W-1:0] xf_num_mag;
  logic [3:0][DEN_W-1:0] xf_den_mag;
  logic [3:0]            dv_valid;
  edge_t [3:0]           dv_edge;
  logic [3:0][T_W-1:0]   dv_quot;
  logic [3:0]            dv_inexact;
  hit_kind_e             kind;

  assign en         = out_ready_i || !out_valid_o;
  assign in_ready_o = en;

  robi_xform #(.FRAC_BITS(FRAC_BITS)) u_xform (
    .clk_i,
    .rst_ni,
    .en_i      (en),
    .valid_i   (in_valid_i),
    .ray_origin_x_i,
    .ray_origin_y_i,
    .ray_dir_x_i,
    .ray_dir_y_i,
    .box_center_x_i,
    .box_center_y_i,
    .axis_u_x_i,
    .axis_u_y_i,
    .axis_v_x_i,
    .axis_v_y_i,
    .half_extent_u_i,
    .half_extent_v_i,
    .valid_o   (xf_valid),
    .edge_o    (xf_edge),
    .num_mag_o (xf_num_mag),
    .den_mag_o (xf_den_mag)
  );

  for (genvar e = 0; e < 4; e++) begin : g_div
    robi_div #(.FRAC_BITS(FRAC_BITS)) u_div (
      .clk_i,
      .rst_ni,
      .en_i      (en),
      .valid_i   (xf_valid),
      .edge_i    (xf_edge[e]),
      .num_mag_i (xf_num_mag[e]),
      .den_mag_i (xf_den_mag[e]),
      .valid_o   (dv_valid[e]),
      .edge_o    (dv_edge[e]),
      .quot_o    (dv_quot[e]),
      .inexact_o (dv_inexact[e])
    );
  end

  robi_clip u_clip (
    .clk_i,
    .rst_ni,
    .en_i            (en),
    .valid_i         (&dv_valid),
    .edge_i          (dv_edge),
    .quot_i          (dv_quot),
    .inexact_i       (dv_inexact),
    .valid_o         (out_valid_o),
    .hit_o           (hit_o),
    .hit_kind_o      (kind),
    .near_distance_o (near_distance_o)
  );

  assign hit_kind_o = kind;

endmodule

// ===== tb/ray_oriented_box_intersect_tb.sv =====
// testbench for the ray versus oriented box pipeline: directed and random queries, scoreboard check
`timescale 1ns / 1ps

module ray_oriented_box_intersect_tb;
  import robi_pkg::*;

  localparam int unsigned FRAC = 16;
  localparam logic [63:0] UNIT = 64'd1 << FRAC;
  localparam logic [63:0] T_LIMIT = 64'h7FFF_FFFF;

  typedef struct {
    logic signed [31:0] ox, oy, dx, dy, cx, cy;
    logic signed [17:0] ux, uy, vx, vy;
    logic [30:0]        eu, ev;
  } query_t;

  typedef struct {
    logic        hit;
    hit_kind_e   kind;
    logic [30:0] near;
  } contact_t;

  class contact_scoreboard;
    contact_t pending[$];
    int       errors = 0;

    function logic [63:0] mag(longint v);
      return v < 0 ? -v : v;
    endfunction

    // exact num * 2^F > den * t
    function bit num_above(longint num, longint den, logic [63:0] t);
      logic [127:0] l, r;
      bit ln, rn;
      l  = {64'd0, mag(num)} << FRAC;
      r  = {64'd0, mag(den)} * {64'd0, t};
      ln = (num < 0) && (l != 0);
      rn = (den < 0) && (r != 0);
      if (ln != rn) return rn;
      if (!ln) return l > r;
      return l < r;
    endfunction

    function logic [63:0] ratio(longint num, longint den);
      logic [127:0] q;
      q = ({64'd0, mag(num)} << FRAC) / {64'd0, mag(den)};
      return (q > T_LIMIT) ? T_LIMIT : q[63:0];
    endfunction

    function void note(query_t q);
      longint rx, ry, bo_u, bo_v, bd_u, bd_v, eu, ev;
      longint dens[4], nums[4];
      logic [63:0] t0, t1;
      bit keep;
      contact_t c;
      rx   = longint'(q.ox) - longint'(q.cx);
      ry   = longint'(q.oy) - longint'(q.cy);
      bo_u = rx * longint'(q.ux) + ry * longint'(q.uy);
      bo_v = rx * longint'(q.vx) + ry * longint'(q.vy);
      bd_u = longint'(q.dx) * longint'(q.ux) + longint'(q.dy) * longint'(q.uy);
      bd_v = longint'(q.dx) * longint'(q.vx) + longint'(q.dy) * longint'(q.vy);
      eu   = longint'({33'd0, q.eu}) << FRAC;
      ev   = longint'({33'd0, q.ev}) << FRAC;
      dens[0] = bd_u;  nums[0] = -bo_u - eu;
      dens[1] = -bd_u; nums[1] = bo_u - eu;
      dens[2] = bd_v;  nums[2] = -bo_v - ev;
      dens[3] = -bd_v; nums[3] = bo_v - ev;
      t0 = 0;
      t1 = T_LIMIT;
      keep = 1;
      for (int i = 0; i < 4 && keep; i++) begin
        if (dens[i] > 0) begin
          if (num_above(nums[i], dens[i], t1)) keep = 0;
          else if (num_above(nums[i], dens[i], t0)) t0 = ratio(nums[i], dens[i]);
        end else if (dens[i] < 0) begin
          if (num_above(nums[i], dens[i], t0)) keep = 0;
          else if (num_above(nums[i], dens[i], t1)) t1 = ratio(nums[i], dens[i]);
        end else begin
          keep = (nums[i] <= 0);
        end
      end
      if (keep) begin
        c.hit  = 1'b1;
        c.kind = (t1 > t0) ? KIND_SEGMENT : KIND_POINT;
        c.near = t0[30:0];
      end else begin
        c.hit  = 1'b0;
        c.kind = KIND_NONE;
        c.near = '0;
      end
      pending.push_back(c);
    endfunction

    function void check(logic hit, logic [1:0] kind, logic [30:0] near);
      contact_t e;
      if (pending.size() == 0) begin
        $error("unexpected result: hit %0d kind %0d near %0h", hit, kind, near);
        errors++;
        return;
      end
      e = pending.pop_front();
      if (hit !== e.hit) begin
        $error("hit: expected %0d actual %0d", e.hit, hit);
        errors++;
      end
      if (kind !== e.kind) begin
        $error("hit_kind: expected %0d actual %0d", e.kind, kind);
        errors++;
      end
      if (near !== e.near) begin
        $error("near_distance: expected %0h actual %0h", e.near, near);
        errors++;
      end
    endfunction
  endclass

  logic clk_i, rst_ni;
  logic in_valid_i, in_ready_o, out_valid_o, out_ready_i;
  logic signed [31:0] ray_origin_x_i, ray_origin_y_i, ray_dir_x_i, ray_dir_y_i;
  logic signed [31:0] box_center_x_i, box_center_y_i;
  logic signed [17:0] axis_u_x_i, axis_u_y_i, axis_v_x_i, axis_v_y_i;
  logic [30:0] half_extent_u_i, half_extent_v_i;
  logic hit_o;
  logic [1:0] hit_kind_o;
  logic [30:0] near_distance_o;

  contact_scoreboard sb = new();
  int send_idle_pct = 0;
  int recv_stall_pct = 0;

  ray_oriented_box_intersect #(.FRAC_BITS(FRAC)) dut (.*);

  always begin
    clk_i = 1'b1; #10;
    clk_i = 1'b0; #10;
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i)
      sb.check(hit_o, hit_kind_o, near_distance_o);
    out_ready_i <= ($urandom_range(99) >= recv_stall_pct);
  end

  function automatic query_t make_query(longint ox, longint oy, longint dx, longint dy,
                                        longint cx, longint cy, longint ux, longint uy,
                                        longint vx, longint vy, longint eu, longint ev);
    query_t q;
    q.ox = 32'(ox); q.oy = 32'(oy); q.dx = 32'(dx); q.dy = 32'(dy);
    q.cx = 32'(cx); q.cy = 32'(cy);
    q.ux = 18'(ux); q.uy = 18'(uy); q.vx = 18'(vx); q.vy = 18'(vy);
    q.eu = 31'(eu); q.ev = 31'(ev);
    return q;
  endfunction

  function automatic int signed srand(int span);
    return int'($urandom_range(2 * span)) - span;
  endfunction

  function automatic query_t random_query();
    query_t q;
    real ang;
    int signed cs, sn;
    if ($urandom_range(99) < 65) begin
      // well-formed box, ray aimed near it
      ang = $urandom_range(6283) / 1000.0;
      cs = $rtoi($cos(ang) * 65536.0);
      sn = $rtoi($sin(ang) * 65536.0);
      if ($urandom_range(3) == 0) begin
        cs = 65536; sn = 0;
      end
      q.cx = srand(200 << 16);
      q.cy = srand(200 << 16);
      q.ux = 18'(cs); q.uy = 18'(sn); q.vx = 18'(-sn); q.vy = 18'(cs);
      q.eu = 31'($urandom_range(40 << 16));
      q.ev = 31'($urandom_range(40 << 16));
      q.ox = q.cx + srand(150 << 16);
      q.oy = q.cy + srand(150 << 16);
      q.dx = (q.cx - q.ox) + srand(60 << 16);
      q.dy = (q.cy - q.oy) + srand(60 << 16);
      if ($urandom_range(7) == 0) q.dx = q.dx >>> $urandom_range(20);
      if ($urandom_range(7) == 0) q.dy = 0;
    end else begin
      q.ox = $urandom; q.oy = $urandom; q.dx = $urandom; q.dy = $urandom;
      q.cx = $urandom; q.cy = $urandom;
      q.ux = 18'($urandom); q.uy = 18'($urandom); q.vx = 18'($urandom); q.vy = 18'($urandom);
      q.eu = 31'($urandom); q.ev = 31'($urandom);
      if ($urandom_range(1)) begin
        q.ox = q.ox >>> 8; q.oy = q.oy >>> 8; q.cx = q.cx >>> 8; q.cy = q.cy >>> 8;
        q.eu = q.eu >> 10; q.ev = q.ev >> 10;
      end
    end
    return q;
  endfunction

  task automatic send(query_t q);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i      <= 1'b1;
    ray_origin_x_i  <= q.ox; ray_origin_y_i <= q.oy;
    ray_dir_x_i     <= q.dx; ray_dir_y_i    <= q.dy;
    box_center_x_i  <= q.cx; box_center_y_i <= q.cy;
    axis_u_x_i      <= q.ux; axis_u_y_i     <= q.uy;
    axis_v_x_i      <= q.vx; axis_v_y_i     <= q.vy;
    half_extent_u_i <= q.eu; half_extent_v_i <= q.ev;
    do @(posedge clk_i); while (!in_ready_o);
    sb.note(q);
  endtask

  initial begin
    #5_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

  initial begin
    query_t dir[$];
    longint u;
    int waited;
    u = UNIT;
    rst_ni <= 1'b0;
    in_valid_i <= 1'b0;
    ray_origin_x_i <= '0; ray_origin_y_i <= '0; ray_dir_x_i <= '0; ray_dir_y_i <= '0;
    box_center_x_i <= '0; box_center_y_i <= '0;
    axis_u_x_i <= '0; axis_u_y_i <= '0; axis_v_x_i <= '0; axis_v_y_i <= '0;
    half_extent_u_i <= '0; half_extent_v_i <= '0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // origin inside, entry from outside, miss, corner point, edge graze, zero direction, ray away, vertical ray
    dir.push_back(make_query(0, 0, u, 0, 0, 0, u, 0, 0, u, 2*u, 2*u));
    dir.push_back(make_query(-10*u, 0, u, 0, 0, 0, u, 0, 0, u, 2*u, 2*u));
    dir.push_back(make_query(-10*u, 5*u, u, 0, 0, 0, u, 0, 0, u, 2*u, 2*u));
    dir.push_back(make_query(2*u, 2*u, u, u, 0, 0, u, 0, 0, u, 2*u, 2*u));
    dir.push_back(make_query(-10*u, 2*u, u, 0, 0, 0, u, 0, 0, u, 2*u, 2*u));
    dir.push_back(make_query(10*u, 0, 0, 0, 0, 0, u, 0, 0, u, 2*u, 2*u));
    dir.push_back(make_query(u, 0, 0, 0, 0, 0, u, 0, 0, u, 2*u, 2*u));
    dir.push_back(make_query(-10*u, 0, -u, 0, 0, 0, u, 0, 0, u, 2*u, 2*u));
    dir.push_back(make_query(10*u, 0, -3*u, 0, 0, 0, u, 0, 0, u, 2*u, 2*u));
    dir.push_back(make_query(0, -9*u, 0, u/2, 0, 0, u, 0, 0, u, 2*u, 2*u));
    // rotated box, tiny direction for saturation
    dir.push_back(make_query(-20*u, -20*u, u, u, 5*u, 5*u, 46341, 46341, -46341, 46341,
                             3*u, u));
    dir.push_back(make_query(-10*u, 0, 1, 0, 0, 0, u, 0, 0, u, 2*u, 2*u));
    dir.push_back(make_query(-3*u, 0, 1, 0, 0, 0, u, 0, 0, u, 2*u, 2*u));
    // field extremes, then zero axes, zero extents, collinear axes and negated axes
    dir.push_back(make_query(-(64'sd1 << 31), -(64'sd1 << 31), -(64'sd1 << 31),
                             -(64'sd1 << 31), -(64'sd1 << 31), -(64'sd1 << 31),
                             -131072, -131072, -131072, -131072, 0, 0));
    dir.push_back(make_query(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                             32'h7FFF_FFFF, 32'h7FFF_FFFF, 131071, 131071, 131071, 131071,
                             31'h7FFF_FFFF, 31'h7FFF_FFFF));
    dir.push_back(make_query(32'h7FFF_FFFF, -(64'sd1 << 31), -(64'sd1 << 31), 32'h7FFF_FFFF,
                             -(64'sd1 << 31), 32'h7FFF_FFFF, -u, u, u, -u,
                             31'h7FFF_FFFF, 31'h7FFF_FFFF));
    dir.push_back(make_query(-5*u, 0, u, 0, 0, 0, 0, 0, 0, 0, u, u));
    dir.push_back(make_query(-5*u, 0, u, 0, 0, 0, u, 0, 0, u, 0, 0));
    dir.push_back(make_query(-5*u, 0, u, 0, 0, 0, u, 0, u, 0, u, u));
    dir.push_back(make_query(-5*u, u, u, 0, 0, 0, -u, 0, 0, -u, u, u));
    foreach (dir[i]) send(dir[i]);

    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 71; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 71; end
        default: begin send_idle_pct = 25; recv_stall_pct = 25; end
      endcase
      repeat (350) send(random_query());
    end
    in_valid_i <= 1'b0;
    send_idle_pct = 0;
    recv_stall_pct = 0;

    waited = 0;
    while (sb.pending.size() != 0 && waited < 20000) begin
      @(posedge clk_i);
      waited++;
    end
    repeat (100) @(posedge clk_i);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
